// ----- rtl/core/ptsd_pkg.sv -----
// shared types and constants for the time-scaled derivative pid block
`default_nettype none

package ptsd_pkg;

    localparam int GAIN_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 40;
    localparam int CORR_W    = 32;
    localparam int ACC_W     = 64;
    localparam int CHUNK_W   = 20;
    localparam int MUL_B_W   = CHUNK_W + 1;
    localparam int PROD_W    = GAIN_W + MUL_B_W;
    localparam int NUM_W     = 34;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int CFG_IDX_W = 2;
    localparam int RATE_SHIFT = 8;
    localparam int GAIN_FRAC  = 12;

    // 1000 us per ms times q.8 scaling
    localparam logic signed [GAIN_W-1:0] RATE_SCALE = 24'sd256000;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptsd_if.sv -----
// valid/ready channel interfaces for samples and corrections
`default_nettype none

interface ptsd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ptsd_pkg::SAMPLE_W-1:0]  error_sample;
    logic        [ptsd_pkg::TIME_W-1:0]    time_now_us;

    modport source (output valid, output error_sample, output time_now_us, input ready);
    modport sink   (input valid, input error_sample, input time_now_us, output ready);
endinterface

interface ptsd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptsd_pkg::CORR_W-1:0]  correction;

    modport source (output valid, output correction, input ready);
    modport sink   (input valid, input correction, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptsd_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module ptsd_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ptsd_pkg::NUM_W-1:0]    dividend,
    input  wire logic [ptsd_pkg::TIME_W-1:0]   divisor,
    output ptsd_pkg::div_stat_t                stat,
    output logic      [ptsd_pkg::NUM_W-1:0]    quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ptsd_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ptsd_pkg::TIME_W-1:0]       rem_reg, rem_next;
    logic [ptsd_pkg::NUM_W-1:0]        quo_reg, quo_next;
    logic [ptsd_pkg::TIME_W-1:0]       dvs_reg, dvs_next;
    logic [ptsd_pkg::TIME_W:0]         rem_shift;
    logic [ptsd_pkg::TIME_W+1:0]       trial;
    logic                              fits;

    assign rem_shift = {rem_reg, quo_reg[ptsd_pkg::NUM_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = !trial[ptsd_pkg::TIME_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ptsd_pkg::DIV_CNT_W'(ptsd_pkg::NUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[ptsd_pkg::TIME_W-1:0] : rem_shift[ptsd_pkg::TIME_W-1:0];
            quo_next = {quo_reg[ptsd_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pid_time_scaled_derivative.sv -----
// pid controller top level with time-scaled derivative and shared multiplier
// the steps are scale, divide, six gain products and finish; no divide when elapsed time is zero
// a new sample is taken only once the last one has passed the rate scaling, the 34-step divider
// and six 24x21 gain products and its correction is in the output register
// the single multiplier is reused for the rate scaling and every gain product
// a finished correction waits in the output register while the next sample is taken
// reset: gains, previous sample, previous timestamp and error sum clear to zero
`default_nettype none

module pid_time_scaled_derivative
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ptsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ptsd_pkg::GAIN_W-1:0]          cfg_wdata,
    ptsd_in_if.sink                                   samples,
    ptsd_out_if.source                                results
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_D_LO,
        ST_D_HI,
        ST_D_ACC,
        ST_D_SHIFT,
        ST_P_LO,
        ST_P_HI,
        ST_I_LO,
        ST_I_HI,
        ST_ACC_LAST,
        ST_FINISH
    } state_t;

    localparam int SW = ptsd_pkg::SAMPLE_W;
    localparam int TW = ptsd_pkg::TIME_W;
    localparam int GW = ptsd_pkg::GAIN_W;
    localparam int UW = ptsd_pkg::SUM_W;
    localparam int AW = ptsd_pkg::ACC_W;
    localparam int CW = ptsd_pkg::CHUNK_W;
    localparam int BW = ptsd_pkg::MUL_B_W;
    localparam int PW = ptsd_pkg::PROD_W;
    localparam int NW = ptsd_pkg::NUM_W;
    localparam int OW = ptsd_pkg::CORR_W;
    localparam int FR = ptsd_pkg::GAIN_FRAC;

    // control and architectural state
    state_t                  state_reg, state_next;
    logic signed [GW-1:0]    gain_p_reg, gain_p_next;
    logic signed [GW-1:0]    gain_d_reg, gain_d_next;
    logic signed [GW-1:0]    gain_i_reg, gain_i_next;
    logic signed [SW-1:0]    prev_sample_reg, prev_sample_next;
    logic        [TW-1:0]    prev_time_reg, prev_time_next;
    logic signed [UW-1:0]    sum_reg, sum_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    prod_vld_reg, prod_vld_next;

    // working payload
    logic signed [SW-1:0]    sample_reg, sample_next;
    logic        [TW-1:0]    time_reg, time_next;
    logic        [TW-1:0]    elapsed_reg, elapsed_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic                    prod_hi_reg, prod_hi_next;
    logic                    num_neg_reg, num_neg_next;
    logic signed [UW-1:0]    rate_reg, rate_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic signed [OW-1:0]    corr_reg, corr_next;

    // shared multiplier operands
    logic signed [GW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;

    logic                    in_take;
    logic                    out_load;
    logic signed [SW:0]      diff;
    logic signed [UW-1:0]    sample_ext;
    logic signed [AW-1:0]    addend;
    logic signed [PW-1:0]    num_abs;
    logic        [UW-1:0]    quo_ext;
    logic signed [UW:0]      sum_wide;
    logic signed [UW-1:0]    sum_sat;
    logic signed [OW-1:0]    corr_sat;
    logic                    corr_ovf;
    logic                    div_start;

    ptsd_pkg::div_stat_t     div_stat;
    logic        [NW-1:0]    div_quo;

    ptsd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_abs[NW-1:0]),
        .divisor  (elapsed_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign samples.ready      = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.correction = corr_reg;

    assign in_take  = samples.valid && samples.ready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);

    assign diff       = {sample_reg[SW-1], sample_reg} - {prev_sample_reg[SW-1], prev_sample_reg};
    assign sample_ext = UW'(sample_reg);
    assign addend     = prod_hi_reg ? (AW'(prod_reg) <<< CW) : AW'(prod_reg);
    assign num_abs    = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign quo_ext    = UW'(div_quo);
    assign div_start  = (state_reg == ST_DIV_START) && (elapsed_reg != '0);

    // running sum saturates at 40 bits
    assign sum_wide = {sum_reg[UW-1], sum_reg} + (UW+1)'(sample_reg);
    always_comb
    begin
        sum_sat = sum_wide[UW-1:0];
        if (sum_wide[UW] != sum_wide[UW-1])
        begin
            sum_sat = sum_wide[UW] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
        end
    end

    // drop the gain fraction with floor, then clamp to 32 bits
    assign corr_ovf = !((acc_reg[AW-1:FR+OW-1] == '0) || (acc_reg[AW-1:FR+OW-1] == '1));
    always_comb
    begin
        corr_sat = acc_reg[FR+OW-1:FR];
        if (corr_ovf)
        begin
            corr_sat = acc_reg[AW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
    end

    // operand select: each 40-bit operand goes in as a low unsigned and a high signed chunk
    always_comb
    begin
        mul_a         = gain_p_reg;
        mul_b         = '0;
        prod_vld_next = 1'b0;
        prod_hi_next  = 1'b0;
        case (state_reg)
            ST_SCALE:
            begin
                mul_a = ptsd_pkg::RATE_SCALE;
                mul_b = BW'(diff);
            end
            ST_D_LO:
            begin
                mul_a         = gain_d_reg;
                mul_b         = {1'b0, rate_reg[CW-1:0]};
                prod_vld_next = 1'b1;
            end
            ST_D_HI:
            begin
                mul_a         = gain_d_reg;
                mul_b         = {rate_reg[UW-1], rate_reg[UW-1:CW]};
                prod_vld_next = 1'b1;
                prod_hi_next  = 1'b1;
            end
            ST_P_LO:
            begin
                mul_a         = gain_p_reg;
                mul_b         = {1'b0, sample_ext[CW-1:0]};
                prod_vld_next = 1'b1;
            end
            ST_P_HI:
            begin
                mul_a         = gain_p_reg;
                mul_b         = {sample_ext[UW-1], sample_ext[UW-1:CW]};
                prod_vld_next = 1'b1;
                prod_hi_next  = 1'b1;
            end
            ST_I_LO:
            begin
                mul_a         = gain_i_reg;
                mul_b         = {1'b0, sum_reg[CW-1:0]};
                prod_vld_next = 1'b1;
            end
            ST_I_HI:
            begin
                mul_a         = gain_i_reg;
                mul_b         = {sum_reg[UW-1], sum_reg[UW-1:CW]};
                prod_vld_next = 1'b1;
                prod_hi_next  = 1'b1;
            end
            default:
            begin
                mul_b = '0;
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        gain_p_next      = gain_p_reg;
        gain_d_next      = gain_d_reg;
        gain_i_next      = gain_i_reg;
        prev_sample_next = prev_sample_reg;
        prev_time_next   = prev_time_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        time_next        = time_reg;
        elapsed_next     = elapsed_reg;
        num_neg_next     = num_neg_reg;
        rate_next        = rate_reg;
        corr_next        = corr_reg;
        acc_next         = acc_reg;

        if (prod_vld_reg)
        begin
            acc_next = acc_reg + addend;
        end

        // config must be written only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            case (cfg_index)
                ptsd_pkg::REG_GAIN_P: gain_p_next = cfg_wdata;
                ptsd_pkg::REG_GAIN_D: gain_d_next = cfg_wdata;
                ptsd_pkg::REG_GAIN_I: gain_i_next = cfg_wdata;
                default:              gain_p_next = gain_p_reg;
            endcase
        end

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next  = samples.error_sample;
                    time_next    = samples.time_now_us;
                    elapsed_next = samples.time_now_us - prev_time_reg;
                    state_next   = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                num_neg_next = prod_reg[PW-1];
                if (elapsed_reg == '0)
                begin
                    // no time has passed: derivative term is zero
                    rate_next  = '0;
                    state_next = ST_D_LO;
                end
                else
                begin
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    // quotient truncates toward zero, sign restored here
                    rate_next  = num_neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
                    state_next = ST_D_LO;
                end
            end
            ST_D_LO:
            begin
                acc_next   = '0;
                state_next = ST_D_HI;
            end
            ST_D_HI:
            begin
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                state_next = ST_D_SHIFT;
            end
            ST_D_SHIFT:
            begin
                // floor of the derivative product by 256
                acc_next   = acc_reg >>> ptsd_pkg::RATE_SHIFT;
                state_next = ST_P_LO;
            end
            ST_P_LO:     state_next = ST_P_HI;
            ST_P_HI:     state_next = ST_I_LO;
            ST_I_LO:     state_next = ST_I_HI;
            ST_I_HI:     state_next = ST_ACC_LAST;
            ST_ACC_LAST: state_next = ST_FINISH;
            ST_FINISH:
            begin
                // hold here while the previous correction is still unclaimed
                if (out_load)
                begin
                    corr_next        = corr_sat;
                    out_valid_next   = 1'b1;
                    sum_next         = sum_sat;
                    prev_sample_next = sample_reg;
                    prev_time_next   = time_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gain_p_reg      <= '0;
            gain_d_reg      <= '0;
            gain_i_reg      <= '0;
            prev_sample_reg <= '0;
            prev_time_reg   <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
            prod_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gain_p_reg      <= gain_p_next;
            gain_d_reg      <= gain_d_next;
            gain_i_reg      <= gain_i_next;
            prev_sample_reg <= prev_sample_next;
            prev_time_reg   <= prev_time_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
            prod_vld_reg    <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        time_reg    <= time_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        prod_hi_reg <= prod_hi_next;
        num_neg_reg <= num_neg_next;
        rate_reg    <= rate_next;
        acc_reg     <= acc_next;
        corr_reg    <= corr_next;
    end

    // divider runs only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV_WAIT))
        else $error("divider busy outside division wait");

    // a taken sample blocks the input until its correction is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("input ready right after a sample transaction");

    // a new correction appears only when the sequencer leaves its final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg == ST_FINISH))
        else $error("correction valid without a finished item");

    // product accumulation never overlaps the clear or the derivative shift
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_D_LO) || (state_reg == ST_D_SHIFT)) |-> !prod_vld_reg)
        else $error("pending product collides with accumulator clear or shift");

endmodule

`default_nettype wire
